FILE: hdl/slf_pkg.sv
// slf_pkg: shared types and constants for the set-associative line fill block
// used by slf_ctrl, slf_dp and set_assoc_line_fill
package slf_pkg;

  // sizes
  localparam int MAX_LINES  = 64;
  localparam int ADDR_BITS  = 16;
  localparam int DATA_BITS  = 32;
  localparam int CFG_BITS   = 7;
  localparam int LINE_BITS  = 6;
  localparam int STEP_BITS  = 4;

  // configuration register indexes
  localparam logic REG_LINE_COUNT = 1'b0;
  localparam logic REG_SET_COUNT  = 1'b1;

  // configuration reset values
  localparam logic [CFG_BITS-1:0] LINE_COUNT_RST = 7'd64;
  localparam logic [CFG_BITS-1:0] SET_COUNT_RST  = 7'd64;

  // fill request item
  typedef struct packed {
    logic [ADDR_BITS-1:0]        block_address;
    logic signed [DATA_BITS-1:0] fill_data;
  } fill_req_t;

  // placement result item
  typedef struct packed {
    logic [LINE_BITS-1:0] line_index;
    logic                 set_full;
  } fill_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic scan_step;
    logic commit;
  } slf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
    logic scan_end;
    logic out_free;
  } slf_stat_t;

endpackage

FILE: hdl/slf_ctrl.sv
// slf_ctrl: sequencer for one fill request at a time
// depends on slf_pkg for command and status structs
module slf_ctrl
  import slf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  slf_stat_t stat,
  output slf_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:   if (req_valid) state <= ST_DIV;
        ST_DIV:    if (stat.div_last) state <= ST_MUL;
        ST_MUL:    state <= ST_SCAN;
        ST_SCAN:   if (stat.scan_end) state <= ST_FINISH;
        ST_FINISH: if (stat.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // commands decoded from state
  assign req_ready     = (state == ST_IDLE);
  assign cmd.load      = (state == ST_IDLE) && req_valid;
  assign cmd.div_step  = (state == ST_DIV);
  assign cmd.mul       = (state == ST_MUL);
  assign cmd.scan_step = (state == ST_SCAN);
  assign cmd.commit    = (state == ST_FINISH) && stat.out_free;

endmodule

FILE: hdl/slf_dp.sv
// slf_dp: config registers, serial divider, base multiply, way scan, line store
// and result register; depends on slf_pkg
module slf_dp
  import slf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  fill_req_t           req,
  input  slf_cmd_t            cmd,
  output slf_stat_t           stat,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fill_rsp_t           rsp
);

  logic [CFG_BITS-1:0]  line_count;
  logic [CFG_BITS-1:0]  set_count;
  logic [CFG_BITS-1:0]  lines_eff;
  logic [CFG_BITS-1:0]  sets_eff;

  logic [ADDR_BITS-1:0] addr;
  logic [DATA_BITS-1:0] data;
  logic [CFG_BITS-1:0]  sets;
  logic [ADDR_BITS-1:0] sh_a;
  logic [ADDR_BITS-1:0] sh_l;
  logic [CFG_BITS-1:0]  rem_a;
  logic [CFG_BITS-1:0]  rem_l;
  logic [CFG_BITS-1:0]  ways;
  logic [STEP_BITS-1:0] step;
  logic [CFG_BITS:0]    try_a;
  logic [CFG_BITS:0]    try_l;
  logic                 fit_l;
  logic [2*CFG_BITS-1:0] prod;

  logic [LINE_BITS-1:0] base;
  logic [LINE_BITS-1:0] way;
  logic [LINE_BITS-1:0] idx;
  logic                 free_hit;
  logic                 last_way;
  logic [LINE_BITS-1:0] pick;
  logic                 full;

  logic [MAX_LINES-1:0] line_valid;
  logic [ADDR_BITS-1:0] line_tag  [MAX_LINES];
  logic [DATA_BITS-1:0] line_word [MAX_LINES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= LINE_COUNT_RST;
      set_count  <= SET_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_COUNT: line_count <= cfg_data;
        REG_SET_COUNT:  set_count  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // effective line and set counts, clamped to sane ranges
  always_comb begin
    if (line_count == '0) begin
      lines_eff = CFG_BITS'(1);
    end else if (line_count > CFG_BITS'(MAX_LINES)) begin
      lines_eff = CFG_BITS'(MAX_LINES);
    end else begin
      lines_eff = line_count;
    end
    if (set_count == '0) begin
      sets_eff = CFG_BITS'(1);
    end else if (set_count > lines_eff) begin
      sets_eff = lines_eff;
    end else begin
      sets_eff = set_count;
    end
  end

  // one restoring step each for addr mod sets and lines div sets
  assign try_a = {rem_a, sh_a[ADDR_BITS-1]};
  assign try_l = {rem_l, sh_l[ADDR_BITS-1]};
  assign fit_l = (try_l >= {1'b0, sets});
  assign prod  = rem_a * ways;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr  <= req.block_address;
      data  <= req.fill_data;
      sets  <= sets_eff;
      sh_a  <= req.block_address;
      sh_l  <= ADDR_BITS'(lines_eff);
      rem_a <= '0;
      rem_l <= '0;
      ways  <= '0;
      step  <= '0;
    end else if (cmd.div_step) begin
      sh_a <= {sh_a[ADDR_BITS-2:0], 1'b0};
      sh_l <= {sh_l[ADDR_BITS-2:0], 1'b0};
      if (try_a >= {1'b0, sets}) begin
        rem_a <= CFG_BITS'(try_a - {1'b0, sets});
      end else begin
        rem_a <= try_a[CFG_BITS-1:0];
      end
      if (fit_l) begin
        rem_l <= CFG_BITS'(try_l - {1'b0, sets});
      end else begin
        rem_l <= try_l[CFG_BITS-1:0];
      end
      ways <= {ways[CFG_BITS-2:0], fit_l};
      step <= step + STEP_BITS'(1);
    end
  end

  // first line of the set
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      base <= prod[LINE_BITS-1:0];
    end
  end

  // way scan, one line per cycle
  assign idx      = base + way;
  assign free_hit = !line_valid[idx];
  assign last_way = ({1'b0, way} + CFG_BITS'(1)) == ways;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      way <= '0;
    end else if (cmd.scan_step) begin
      if (free_hit) begin
        pick <= idx;
        full <= 1'b0;
      end else if (last_way) begin
        pick <= base;
        full <= 1'b1;
      end else begin
        way <= way + LINE_BITS'(1);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (cmd.commit) begin
      line_valid[pick] <= 1'b1;
    end
  end

  // tag and data store
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      line_tag[pick]  <= addr;
      line_word[pick] <= data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.line_index <= pick;
      rsp.set_full   <= full;
    end
  end

  // status to the controller
  assign stat.div_last = (step == {STEP_BITS{1'b1}});
  assign stat.scan_end = free_hit || last_way;
  assign stat.out_free = !rsp_valid || rsp_ready;

endmodule

FILE: hdl/set_assoc_line_fill.sv
// set_assoc_line_fill: top level of the set-associative line placement block
// depends on slf_pkg, slf_ctrl and slf_dp
//
// Each fill request item picks set = address mod set count, scans that set's
// ways in order for the first free line (else takes the set's first line and
// flags set_full), marks it valid and stores tag and data. One item is worked
// on at a time, in these steps: acceptance, the bit-serial divider that forms
// address mod sets and lines / sets together, the base multiply, the scan of
// the set's ways up to the first free one or the last one, and the commit,
// which waits until the output register is free. A finished result sits in
// an output register, so the next item is taken while it waits.
// Configuration writes are taken any time the block is idle; there is no
// clearing pass after reset.
module set_assoc_line_fill
  import slf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                req_valid,
  output logic                req_ready,
  input  fill_req_t           req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fill_rsp_t           rsp
);

  slf_cmd_t  cmd;
  slf_stat_t stat;

  // sequencer
  slf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  slf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(rsp_valid && !rsp_ready))
    else $error("result overwritten");

  // a result shows up only after a commit
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.commit))
    else $error("result without commit");

  // no new item is taken while dividing
  a_busy_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !req_ready)
    else $error("accept during divide");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> cmd.div_step)
    else $error("divide not started");

endmodule

FILE: tb/fill_checker.sv
// fill_checker: watches the configuration port and both item channels of
// set_assoc_line_fill, predicts each line placement and compares the results
// depends on slf_pkg
module fill_checker
  import slf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                req_valid,
  input  logic                req_ready,
  input  fill_req_t           req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  fill_rsp_t           rsp,
  output int                  errors,
  output int                  pending
);

  // shadow copy of the registers and the line valid bits
  logic [CFG_BITS-1:0]  lines_reg;
  logic [CFG_BITS-1:0]  sets_reg;
  logic [MAX_LINES-1:0] valid_bits;
  fill_rsp_t            placements[$];

  // choose the line for one fill and mark it valid
  function automatic fill_rsp_t place_line(input logic [ADDR_BITS-1:0] addr);
    int unsigned lines;
    int unsigned sets;
    int unsigned ways;
    int unsigned base_line;
    int unsigned pick;
    int unsigned w;
    fill_rsp_t   r;
    // zero counts act as one, too many lines saturate, sets never exceed lines
    lines = lines_reg;
    if (lines == 0) lines = 1;
    if (lines > MAX_LINES) lines = MAX_LINES;
    sets = sets_reg;
    if (sets == 0) sets = 1;
    if (sets > lines) sets = lines;
    ways = lines / sets;
    base_line = (addr % sets) * ways;
    pick = base_line;
    r.set_full = 1'b1;
    // first free way wins, else the set's first line is replaced
    for (w = 0; w < ways && r.set_full; w++) begin
      if (!valid_bits[base_line + w]) begin
        pick = base_line + w;
        r.set_full = 1'b0;
      end
    end
    valid_bits[pick] = 1'b1;
    r.line_index = LINE_BITS'(pick);
    return r;
  endfunction

  always @(posedge clk) begin : watch_fills
    fill_rsp_t want;
    int        bad;
    bad = 0;
    if (rst) begin
      lines_reg = LINE_COUNT_RST;
      sets_reg = SET_COUNT_RST;
      valid_bits = '0;
      placements.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_LINE_COUNT) lines_reg = cfg_data;
        else sets_reg = cfg_data;
      end
      // results are checked before this edge's item is predicted
      if (rsp_valid && rsp_ready) begin
        if (placements.size() == 0) begin
          bad++;
          $display("%0t: result with none expected: line_index %0d set_full %0b",
                   $time, rsp.line_index, rsp.set_full);
        end else begin
          want = placements.pop_front();
          if (rsp.line_index !== want.line_index) begin
            bad++;
            $display("%0t: line_index expected %0d got %0d",
                     $time, want.line_index, rsp.line_index);
          end
          if (rsp.set_full !== want.set_full) begin
            bad++;
            $display("%0t: set_full expected %0b got %0b",
                     $time, want.set_full, rsp.set_full);
          end
        end
      end
      if (req_valid && req_ready) placements.push_back(place_line(req.block_address));
    end
    errors <= errors + bad;
    pending <= placements.size();
  end

endmodule

FILE: tb/tb.sv
// tb: stimulus and verdict for set_assoc_line_fill
// depends on slf_pkg, set_assoc_line_fill and fill_checker
module tb;
  import slf_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_LINE_COUNT;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                req_valid = 1'b0;
  fill_req_t           req = '0;
  logic                rsp_ready = 1'b1;
  logic                req_ready;
  logic                rsp_valid;
  fill_rsp_t           rsp;
  int                  errors;
  int                  pending;
  bit                  steady = 1'b0;
  int                  rsp_hold = 0;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  set_assoc_line_fill u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  fill_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  // result side stalls: random low bursts between high stretches, none in steady mode
  always @(posedge clk) begin
    if (steady) begin
      rsp_ready <= 1'b1;
    end else if (rsp_hold > 0) begin
      rsp_hold--;
    end else if (rsp_ready && $urandom_range(0, 3) == 0) begin
      rsp_ready <= 1'b0;
      rsp_hold = $urandom_range(0, 17);
    end else if (!rsp_ready) begin
      rsp_ready <= 1'b1;
      rsp_hold = $urandom_range(0, 40);
    end
  end

  // write both registers on back to back cycles
  task automatic program_cfg(input logic [CFG_BITS-1:0] lines,
                             input logic [CFG_BITS-1:0] sets);
    cfg_we <= 1'b1;
    cfg_index <= REG_LINE_COUNT;
    cfg_data <= lines;
    @(posedge clk);
    cfg_index <= REG_SET_COUNT;
    cfg_data <= sets;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one fill item, optionally after an idle burst
  task automatic send_fill(input logic [ADDR_BITS-1:0] addr,
                           input logic [DATA_BITS-1:0] data, input int gap_pct);
    fill_req_t item;
    item.block_address = addr;
    item.fill_data = data;
    if (!steady && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // stop sending and wait for every expected placement
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int ph;
    int k;
    int lines;
    int sets;
    int gap_pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero counts: a single line, second fill finds it full
    program_cfg(7'd0, 7'd0);
    send_fill(16'h0000, 32'h8000_0000, 30);
    send_fill(16'hFFFF, 32'h7FFF_FFFF, 30);
    send_fill(16'h5555, 32'hFFFF_FFFF, 30);
    drain();
    // more sets than lines: one way per set
    program_cfg(7'd3, 7'd5);
    send_fill(16'h0001, 32'h0000_0000, 30);
    send_fill(16'h0002, 32'h0000_0001, 30);
    send_fill(16'hFFFF, 32'hAAAA_AAAA, 30);
    send_fill(16'hAAAA, 32'h5555_5555, 30);
    drain();
    // sets not dividing lines: three ways, last line never used
    program_cfg(7'd7, 7'd2);
    send_fill(16'h0001, 32'h1234_5678, 30);
    send_fill(16'h0003, 32'hFEDC_BA98, 30);
    send_fill(16'h0005, 32'h0000_FFFF, 30);
    send_fill(16'h0007, 32'hFFFF_0000, 30);
    send_fill(16'h0000, 32'h8000_0001, 30);
    drain();
    // line count above the maximum, fully associative
    program_cfg(7'd127, 7'd1);
    send_fill(16'h8000, 32'h7FFF_FFFE, 30);
    send_fill(16'h7FFF, 32'h0F0F_0F0F, 30);
    drain();
    // direct mapped at full size
    program_cfg(7'd64, 7'd64);
    send_fill(16'h003F, 32'hF0F0_F0F0, 30);
    send_fill(16'h0008, 32'h0000_0002, 30);
    drain();

    // random phases, the last one without idling on either side
    for (ph = 0; ph < 16; ph++) begin
      case ($urandom_range(0, 7))
        0: begin
          lines = $urandom_range(0, 127);
          sets = $urandom_range(0, 127);
        end
        1: begin
          lines = 64;
          sets = 1;
        end
        2: begin
          lines = $urandom_range(65, 127);
          sets = $urandom_range(65, 127);
        end
        default: begin
          lines = $urandom_range(1, 64);
          sets = $urandom_range(1, lines);
          while (lines % sets != 0) sets--;
        end
      endcase
      if (ph == 15) steady <= 1'b1;
      program_cfg(lines[CFG_BITS-1:0], sets[CFG_BITS-1:0]);
      gap_pct = $urandom_range(0, 40);
      for (k = 0; k < 100; k++) begin
        send_fill(ADDR_BITS'($urandom()), $urandom(), gap_pct);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
